### rtl/core/stp_pkg.sv
`default_nettype none

package stp_pkg;

	localparam int CoordW = 24;
	localparam int FracW = 8;
	localparam int IntW = CoordW - FracW;
	localparam int SizeW = 10;
	localparam int CountW = 11;
	localparam int IndexW = 20;
	localparam int RowW = 10;
	localparam int DivStages = 8;
	localparam int StepsPerStage = IntW / DivStages;
	localparam int RemW = SizeW + FracW;
	localparam int ProdW = RemW + SizeW;
	localparam int AreaW = 2 * SizeW;
	localparam logic [CountW-1:0] MaxTileCount = 11'd1024;

	typedef enum logic [2:0] {
		CFG_DIAMOND_MODE = 3'd0,
		CFG_TILES_ACROSS = 3'd1,
		CFG_TILES_DOWN   = 3'd2,
		CFG_TILE_WIDTH   = 3'd3,
		CFG_TILE_HEIGHT  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic              diamond_mode;
		logic [CountW-1:0] tiles_across;
		logic [CountW-1:0] tiles_down;
		logic [SizeW-1:0]  tile_width;
		logic [SizeW-1:0]  tile_height;
	} cfg_t;

	// partial remainder and the dividend bits that turn into quotient bits
	typedef struct packed {
		logic [SizeW-1:0] rem;
		logic [IntW-1:0]  nq;
	} div_lane_t;

	typedef struct packed {
		logic [IntW-1:0]  qx;
		logic [IntW-1:0]  qy;
		logic [IntW-1:0]  qs;
		logic [SizeW-1:0] rem_x;
		logic [SizeW-1:0] rem_y;
		logic [FracW-1:0] frac_x;
		logic [FracW-1:0] frac_y;
		logic             xs_neg;
	} cell_t;

	typedef struct packed {
		logic [RowW-1:0] row;
		logic [RowW-1:0] col;
		logic            hit;
	} pick_t;

	// one restoring division step
	function automatic div_lane_t div_step(div_lane_t l, logic [SizeW-1:0] d);
		logic [SizeW:0] trial;
		logic [SizeW:0] diff;
		logic           ge;
		div_lane_t      r;
		trial = {l.rem, l.nq[IntW-1]};
		diff  = trial - {1'b0, d};
		ge    = trial >= {1'b0, d};
		r.rem = ge ? diff[SizeW-1:0] : trial[SizeW-1:0];
		r.nq  = {l.nq[IntW-2:0], ge};
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/stp_divider.sv
`default_nettype none

module stp_divider import stp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [CoordW-1:0] in_x,
	input  wire logic [CoordW-1:0] in_y,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output cell_t                  out_cell
);

	logic                   v_s   [0:DivStages];
	div_lane_t              lx_s  [0:DivStages];
	div_lane_t              ly_s  [0:DivStages];
	div_lane_t              ls_s  [0:DivStages];
	logic [FracW-1:0]       fx_s  [0:DivStages];
	logic [FracW-1:0]       fy_s  [0:DivStages];
	logic                   neg_s [0:DivStages];
	logic [DivStages:0]     adv;

	logic [CoordW-1:0]      half_w;
	logic [CoordW-1:0]      shifted_x;

	always_comb begin
		adv[DivStages] = !v_s[DivStages] || out_ready;
		for (int k = DivStages - 1; k >= 0; k--) begin
			adv[k] = !v_s[k] || adv[k+1];
		end
	end

	assign in_ready = adv[0];

	// odd rows: x shifted left by half a tile, in world units times 256
	assign half_w    = CoordW'({cfg.tile_width, 7'b0});
	assign shifted_x = in_x - half_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv[0]) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			lx_s[0]  <= '{rem: '0, nq: in_x[CoordW-1:FracW]};
			ly_s[0]  <= '{rem: '0, nq: in_y[CoordW-1:FracW]};
			ls_s[0]  <= '{rem: '0, nq: shifted_x[CoordW-1:FracW]};
			fx_s[0]  <= in_x[FracW-1:0];
			fy_s[0]  <= in_y[FracW-1:0];
			neg_s[0] <= in_x < half_w;
		end
	end

	for (genvar k = 1; k <= DivStages; k++) begin : g_stage
		div_lane_t nx;
		div_lane_t ny;
		div_lane_t ns;

		always_comb begin
			nx = lx_s[k-1];
			ny = ly_s[k-1];
			ns = ls_s[k-1];
			for (int i = 0; i < StepsPerStage; i++) begin
				nx = div_step(nx, cfg.tile_width);
				ny = div_step(ny, cfg.tile_height);
				ns = div_step(ns, cfg.tile_width);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv[k]) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				lx_s[k]  <= nx;
				ly_s[k]  <= ny;
				ls_s[k]  <= ns;
				fx_s[k]  <= fx_s[k-1];
				fy_s[k]  <= fy_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	assign out_valid       = v_s[DivStages];
	assign out_cell.qx     = lx_s[DivStages].nq;
	assign out_cell.qy     = ly_s[DivStages].nq;
	assign out_cell.qs     = ls_s[DivStages].nq;
	assign out_cell.rem_x  = lx_s[DivStages].rem;
	assign out_cell.rem_y  = ly_s[DivStages].rem;
	assign out_cell.frac_x = fx_s[DivStages];
	assign out_cell.frac_y = fy_s[DivStages];
	assign out_cell.xs_neg = neg_s[DivStages];

endmodule

`default_nettype wire

### rtl/core/stp_region.sv
`default_nettype none

module stp_region import stp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire cell_t in_cell,
	output logic       out_valid,
	input  wire logic  out_ready,
	output pick_t      out_pick
);

	localparam int SumW = ProdW + 2;

	typedef enum logic [2:0] {
		RGN_CENTRE,
		RGN_UPPER_LEFT,
		RGN_UPPER_RIGHT,
		RGN_LOWER_LEFT,
		RGN_LOWER_RIGHT
	} region_t;

	logic             v_s1, v_s2, v_s3;
	logic             adv1, adv2, adv3;

	// stage 1: products
	logic [ProdW-1:0] p_s1, q_s1;
	logic [AreaW-1:0] area_s1;
	logic             upper_s1, lower_s1;
	logic [IntW-1:0]  qx_s1, qy_s1, qs_s1;
	logic             neg_s1;

	// stage 2: region
	region_t          rgn_s2;
	logic [IntW-1:0]  qx_s2, qy_s2, qs_s2;
	logic             neg_s2;

	// stage 3: picked tile
	pick_t            pick_s3;

	logic [RemW-1:0]  rx, ry;
	logic [SumW-1:0]  p_ext, q_ext, r128, r384;
	region_t          rgn_next;

	logic [IntW:0]    row;
	logic [IntW-1:0]  col;
	logic             row_ok;
	logic             size_ok;
	logic             hit_next;

	assign adv3     = !v_s3 || out_ready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	assign rx = {in_cell.rem_x, in_cell.frac_x};
	assign ry = {in_cell.rem_y, in_cell.frac_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			p_s1     <= ProdW'(ry) * ProdW'(cfg.tile_width);
			q_s1     <= ProdW'(rx) * ProdW'(cfg.tile_height);
			area_s1  <= AreaW'(cfg.tile_width) * AreaW'(cfg.tile_height);
			upper_s1 <= {ry, 1'b0} < {1'b0, cfg.tile_height, 8'b0};
			lower_s1 <= {ry, 1'b0} > {1'b0, cfg.tile_height, 8'b0};
			qx_s1    <= in_cell.qx;
			qy_s1    <= in_cell.qy;
			qs_s1    <= in_cell.qs;
			neg_s1   <= in_cell.xs_neg;
		end
	end

	// comparisons scaled up by the fraction scale: a whole tile is area times 256
	assign p_ext = SumW'(p_s1);
	assign q_ext = SumW'(q_s1);
	assign r128  = SumW'({area_s1, 7'b0});
	assign r384  = r128 + {r128[SumW-2:0], 1'b0};

	always_comb begin
		rgn_next = RGN_CENTRE;
		if (cfg.diamond_mode) begin
			if (upper_s1) begin
				if (p_ext + q_ext < r128) rgn_next = RGN_UPPER_LEFT;
				else if (p_ext + r128 < q_ext) rgn_next = RGN_UPPER_RIGHT;
			end else if (lower_s1) begin
				if (p_ext > q_ext + r128) rgn_next = RGN_LOWER_LEFT;
				else if (p_ext + q_ext > r384) rgn_next = RGN_LOWER_RIGHT;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			rgn_s2 <= rgn_next;
			qx_s2  <= qx_s1;
			qy_s2  <= qy_s1;
			qs_s2  <= qs_s1;
			neg_s2 <= neg_s1;
		end
	end

	assign size_ok = (cfg.tiles_across != '0) && (cfg.tiles_down != '0)
		&& (cfg.tile_width != '0) && (cfg.tile_height != '0);

	always_comb begin
		row_ok = 1'b1;
		row    = {qy_s2, 1'b0};
		case (rgn_s2)
			RGN_UPPER_LEFT: begin
				if (qy_s2 == '0 || qx_s2 == '0) row_ok = 1'b0;
				else row = {qy_s2, 1'b0} - (IntW + 1)'(1);
			end
			RGN_UPPER_RIGHT: begin
				if (qy_s2 == '0 || qx_s2 >= IntW'(cfg.tiles_across)) row_ok = 1'b0;
				else row = {qy_s2, 1'b0} - (IntW + 1)'(1);
			end
			RGN_LOWER_LEFT: begin
				if (qx_s2 == '0) row_ok = 1'b0;
				else row = {qy_s2, 1'b1};
			end
			RGN_LOWER_RIGHT: begin
				if (qx_s2 >= IntW'(cfg.tiles_across)) row_ok = 1'b0;
				else row = {qy_s2, 1'b1};
			end
			default: ;
		endcase

		if (!cfg.diamond_mode) begin
			row = {1'b0, qy_s2};
			col = qx_s2;
		end else if (row[0]) begin
			col = neg_s2 ? '0 : qs_s2;
		end else begin
			col = qx_s2;
		end

		hit_next = size_ok && row_ok && (row < (IntW + 1)'(cfg.tiles_down))
			&& (col < IntW'(cfg.tiles_across));
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			pick_s3.hit <= hit_next;
			pick_s3.row <= hit_next ? row[RowW-1:0] : '0;
			pick_s3.col <= hit_next ? col[RowW-1:0] : '0;
		end
	end

	assign out_valid = v_s3;
	assign out_pick  = pick_s3;

endmodule

`default_nettype wire

### rtl/core/stp_index.sv
`default_nettype none

module stp_index import stp_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cfg_t                cfg,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire pick_t               in_pick,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [2*RowW+IndexW-1:0] out_data,
	output logic                     out_hit
);

	localparam int LinW = RowW + CountW;
	localparam int DataW = 2 * RowW + IndexW;

	typedef struct packed {
		logic [DataW-1:0] data;
		logic             hit;
	} result_t;

	logic             v_s1;
	logic             adv1;
	logic [LinW-1:0]  lin_s1;
	pick_t            pick_s1;

	result_t          res_next;
	result_t          out_q, skid_q;
	logic             out_v_q, skid_v_q;
	logic             buf_ready;
	logic             buf_fire;
	logic [IndexW-1:0] index_next;

	assign buf_ready = !skid_v_q;
	assign adv1      = !v_s1 || buf_ready;
	assign in_ready  = adv1;
	assign buf_fire  = v_s1 && buf_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			lin_s1  <= LinW'(in_pick.row) * LinW'(cfg.tiles_across);
			pick_s1 <= in_pick;
		end
	end

	// a miss carries zero row and column, so the index comes out zero as well
	assign index_next    = lin_s1[IndexW-1:0] + IndexW'(pick_s1.col);
	assign res_next.data = {pick_s1.col, pick_s1.row, index_next};
	assign res_next.hit  = pick_s1.hit;

	// output register with a skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || out_ready) begin
			out_v_q  <= skid_v_q || buf_fire;
			skid_v_q <= 1'b0;
		end else if (buf_fire) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_ready) begin
			out_q <= skid_v_q ? skid_q : res_next;
		end else if (buf_fire) begin
			skid_q <= res_next;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q.data;
	assign out_hit   = out_q.hit;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry holds a transaction while the output is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		buf_fire && out_v_q && !out_ready |=> skid_v_q && out_v_q)
		else $error("transaction lost while the output was stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_q.hit |-> out_q.data == '0)
		else $error("miss result carries nonzero tile fields");

	a_no_take_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !out_ready |=> $stable(skid_q) && skid_v_q)
		else $error("skid entry changed while the output was stalled");

endmodule

`default_nettype wire

### rtl/core/staggered_tile_picker_unit.sv
// Staggered tile picker: maps a point given as unsigned 16.8 fixed point to the
// map tile that holds it, in a rectangular grid or in staggered diamond layout,
// and returns the linear tile index, row, column and a hit flag. The block is
// fully pipelined and takes one transaction per clock unless m_tready holds it back;
// an accepted input reaches m_tvalid through the input register and the three
// restoring dividers that resolve two quotient bits in each of eight stages, followed
// by the cell-region multiplies and compares, the index multiply and the output
// register. A skid entry behind the output register keeps m_tready off the
// combinational ready path back to s_tready.
// Configuration is written through cfg_we/cfg_index/cfg_data and must only
// change while no transaction is in flight.
`default_nettype none

module staggered_tile_picker_unit import stp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [CountW-1:0] cfg_data,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [47:0]       s_tdata,  // point_x, point_y
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [39:0]            m_tdata,  // tile_index, tile_row, tile_column
	output logic [0:0]             m_tuser   // hit
);

	cfg_t             cfg_q;

	logic             div_valid, div_ready;
	cell_t            div_cell;
	logic             rgn_valid, rgn_ready;
	pick_t            rgn_pick;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DIAMOND_MODE: cfg_q.diamond_mode <= cfg_data[0];
				CFG_TILES_ACROSS: cfg_q.tiles_across <=
					(cfg_data > MaxTileCount) ? MaxTileCount : cfg_data;
				CFG_TILES_DOWN:   cfg_q.tiles_down <=
					(cfg_data > MaxTileCount) ? MaxTileCount : cfg_data;
				CFG_TILE_WIDTH:   cfg_q.tile_width <= cfg_data[SizeW-1:0];
				CFG_TILE_HEIGHT:  cfg_q.tile_height <= cfg_data[SizeW-1:0];
				default: ;
			endcase
		end
	end

	stp_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_x      (s_tdata[CoordW-1:0]),
		.in_y      (s_tdata[2*CoordW-1:CoordW]),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_cell  (div_cell)
	);

	stp_region u_region (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (div_valid),
		.in_ready  (div_ready),
		.in_cell   (div_cell),
		.out_valid (rgn_valid),
		.out_ready (rgn_ready),
		.out_pick  (rgn_pick)
	);

	stp_index u_index (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (rgn_valid),
		.in_ready  (rgn_ready),
		.in_pick   (rgn_pick),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_hit   (m_tuser[0])
	);

endmodule

`default_nettype wire
